// ===== hdl/fast9_pkg.sv =====
`default_nettype none

package fast9_pkg;

  localparam int unsigned RingLen = 16;
  localparam int unsigned RunLen  = 9;
  localparam int unsigned PixBits = 8;
  localparam int unsigned HalfLen = RingLen / 2;
  localparam int unsigned ScoreW  = 12;

  localparam logic [PixBits-1:0] ThrReset = 8'd20;

  // Per ring pixel result of one lane
  typedef struct packed {
    logic [PixBits-1:0] abs_diff;
    logic               bright;
    logic               dark;
  } lane_res_t;

endpackage

`default_nettype wire

// ===== hdl/fast9_lane.sv =====
`default_nettype none

module fast9_lane import fast9_pkg::*; (
  input  wire logic [PixBits-1:0] center_i,
  input  wire logic [PixBits-1:0] pixel_i,
  input  wire logic [PixBits-1:0] thr_i,
  output      lane_res_t          res_o
);

  logic               above;
  logic [PixBits-1:0] mag;

  assign above = pixel_i > center_i;
  assign mag   = above ? (pixel_i - center_i) : (center_i - pixel_i);

  assign res_o.abs_diff = mag;
  assign res_o.bright   = above && (mag > thr_i);
  assign res_o.dark     = (pixel_i < center_i) && (mag > thr_i);

endmodule

`default_nettype wire

// ===== hdl/fast9_merge.sv =====
`default_nettype none

module fast9_merge import fast9_pkg::*; (
  input  wire lane_res_t [RingLen-1:0] lanes_i,
  output      logic                    found_o,
  output      logic [ScoreW-1:0]       score_o
);

  logic [RingLen-1:0]   bright_mask;
  logic [RingLen-1:0]   dark_mask;
  logic [2*RingLen-1:0] bright_twice;
  logic [2*RingLen-1:0] dark_twice;
  logic [RingLen-1:0]   bright_hit;
  logic [RingLen-1:0]   dark_hit;

  logic [PixBits:0]   sum1 [HalfLen];
  logic [PixBits+1:0] sum2 [HalfLen/2];
  logic [PixBits+2:0] sum3 [HalfLen/4];
  logic [ScoreW-1:0]  sum4;

  always_comb begin
    for (int i = 0; i < RingLen; i++) begin
      bright_mask[i] = lanes_i[i].bright;
      dark_mask[i]   = lanes_i[i].dark;
    end
  end

  assign bright_twice = {bright_mask, bright_mask};
  assign dark_twice   = {dark_mask, dark_mask};

  // Circular run check: one window of nine for every start position
  always_comb begin
    for (int s = 0; s < RingLen; s++) begin
      bright_hit[s] = &bright_twice[s +: RunLen];
      dark_hit[s]   = &dark_twice[s +: RunLen];
    end
  end

  // Balanced adder tree over the absolute differences
  always_comb begin
    for (int i = 0; i < HalfLen; i++) begin
      sum1[i] = {1'b0, lanes_i[2*i].abs_diff} + {1'b0, lanes_i[2*i+1].abs_diff};
    end
    for (int i = 0; i < HalfLen/2; i++) begin
      sum2[i] = {1'b0, sum1[2*i]} + {1'b0, sum1[2*i+1]};
    end
    for (int i = 0; i < HalfLen/4; i++) begin
      sum3[i] = {1'b0, sum2[2*i]} + {1'b0, sum2[2*i+1]};
    end
    sum4 = {1'b0, sum3[0]} + {1'b0, sum3[1]};
  end

  assign found_o = (|bright_hit) || (|dark_hit);
  assign score_o = found_o ? sum4 : '0;

endmodule

`default_nettype wire

// ===== hdl/fast9_corner_score_top.sv =====
`default_nettype none

// Channel   Valid          Stall          Payload
// input     in_valid_i     in_stall_o     center_pixel_i, ring_first_half_i,
//                                         ring_second_half_i
// output    out_valid_o    out_stall_i    corner_found_o, corner_score_o
// config    cfg_we_i       (none)         cfg_wdata_i (brightness threshold)
//
// One item per cycle sustained while the output is not stalled; each item is
// registered after the lane compares, then after run check and adder tree.
// Reset empties both stages and loads the threshold with 20.
// An output stall holds the result; an empty stage still accepts, so a
// stall reaches the input only when both stages are full.

module fast9_corner_score_top import fast9_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [PixBits-1:0]   cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [PixBits-1:0]   center_pixel_i,
  input  wire logic [63:0]          ring_first_half_i,
  input  wire logic [63:0]          ring_second_half_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic                 corner_found_o,
  output      logic [ScoreW-1:0]    corner_score_o
);

  logic [PixBits-1:0] thr_q;

  lane_res_t [RingLen-1:0] lanes_d, lanes_q;
  logic                    s1_valid_q;
  logic                    s2_valid_q;
  logic                    found_d, found_q;
  logic [ScoreW-1:0]       score_d, score_q;
  logic                    s1_adv;
  logic                    s2_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  for (genvar i = 0; i < RingLen; i++) begin : g_lane
    logic [PixBits-1:0] pix;
    if (i < HalfLen) begin : g_lo
      assign pix = ring_first_half_i[i*PixBits +: PixBits];
    end else begin : g_hi
      assign pix = ring_second_half_i[(i-HalfLen)*PixBits +: PixBits];
    end

    fast9_lane u_lane (
      .center_i (center_pixel_i),
      .pixel_i  (pix),
      .thr_i    (thr_q),
      .res_o    (lanes_d[i])
    );
  end

  fast9_merge u_merge (
    .lanes_i (lanes_q),
    .found_o (found_d),
    .score_o (score_d)
  );

  // A stage loads when it is empty or its content moves on this cycle
  assign s2_adv     = !s2_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      lanes_q <= lanes_d;
    end
    if (s2_adv && s1_valid_q) begin
      found_q <= found_d;
      score_q <= score_d;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign corner_found_o = found_q;
  assign corner_score_o = score_q;

endmodule

`default_nettype wire

// ===== sim/fast9_corner_score_top_tb.sv =====
`timescale 1ns / 1ps

module fast9_corner_score_top_tb;
  import fast9_pkg::*;

  typedef struct packed {
    logic              found;
    logic [ScoreW-1:0] score;
  } corner_res_t;

  class score_checker;
    corner_res_t        pending_scores[$];
    logic [PixBits-1:0] threshold;
    int                 errors;

    function new();
      threshold = ThrReset;
      errors    = 0;
    endfunction

    static function bit has_long_run(logic [RingLen-1:0] mask);
      logic [2*RingLen-1:0] twice;
      twice = {mask, mask};
      for (int s = 0; s < RingLen; s++) begin
        if (&twice[s +: RunLen]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_window(logic [PixBits-1:0] center, logic [63:0] first_half,
                              logic [63:0] second_half);
      logic [2*64-1:0]    ring;
      logic [RingLen-1:0] bright;
      logic [RingLen-1:0] dark;
      int                 diff;
      int                 sum;
      int                 thr;
      corner_res_t        res;
      ring   = {second_half, first_half};
      bright = '0;
      dark   = '0;
      sum    = 0;
      thr    = int'(threshold);
      for (int i = 0; i < RingLen; i++) begin
        diff = int'(ring[PixBits*i +: PixBits]) - int'(center);
        sum += (diff < 0) ? -diff : diff;
        bright[i] = diff > thr;
        dark[i]   = diff < -thr;
      end
      res.found = has_long_run(bright) || has_long_run(dark);
      res.score = res.found ? sum[ScoreW-1:0] : '0;
      pending_scores.push_back(res);
    endfunction

    function void check_score(logic found, logic [ScoreW-1:0] score);
      corner_res_t want;
      if (pending_scores.size() == 0) begin
        $error("unexpected result: corner_found %0d corner_score %0d", found, score);
        errors++;
        return;
      end
      want = pending_scores.pop_front();
      if (found !== want.found) begin
        $error("corner_found: expected %0d, got %0d", want.found, found);
        errors++;
      end
      if (score !== want.score) begin
        $error("corner_score: expected %0d, got %0d", want.score, score);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i              = 1'b0;
  logic                 rst_ni             = 1'b0;
  logic                 cfg_we_i           = 1'b0;
  logic [PixBits-1:0]   cfg_wdata_i        = '0;
  logic                 in_valid_i         = 1'b0;
  logic                 in_stall_o;
  logic [PixBits-1:0]   center_pixel_i     = '0;
  logic [63:0]          ring_first_half_i  = '0;
  logic [63:0]          ring_second_half_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i        = 1'b0;
  logic                 corner_found_o;
  logic [ScoreW-1:0]    corner_score_o;

  int           idle_pct = 13;
  score_checker checker_h;

  fast9_corner_score_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .center_pixel_i     (center_pixel_i),
    .ring_first_half_i  (ring_first_half_i),
    .ring_second_half_i (ring_second_half_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .corner_found_o     (corner_found_o),
    .corner_score_o     (corner_score_o)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        checker_h.note_window(center_pixel_i, ring_first_half_i, ring_second_half_i);
      end
      if (out_valid_o && !out_stall_i) begin
        checker_h.check_score(corner_found_o, corner_score_o);
      end
    end
  end

  initial begin
    #2000000;
    $display("fast9_corner_score_top_tb NOT OK");
    $finish;
  end

  function automatic logic [PixBits-1:0] clamp_pixel(int v);
    if (v < 0) return '0;
    if (v > 255) return 8'hFF;
    return v[PixBits-1:0];
  endfunction

  function automatic logic [127:0] ring_by_mask(logic [RingLen-1:0] mask,
                                                logic [PixBits-1:0] on_pix,
                                                logic [PixBits-1:0] off_pix);
    logic [127:0] ring;
    for (int i = 0; i < RingLen; i++) begin
      ring[PixBits*i +: PixBits] = mask[i] ? on_pix : off_pix;
    end
    return ring;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_window(logic [PixBits-1:0] center, logic [127:0] ring);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    center_pixel_i     <= center;
    ring_first_half_i  <= ring[63:0];
    ring_second_half_i <= ring[127:64];
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic set_threshold(logic [PixBits-1:0] value);
    in_valid_i <= 1'b0;
    while (checker_h.pending_scores.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    checker_h.threshold = value;
  endtask

  // Mostly windows with a contiguous run around the threshold, the rest raw noise.
  task automatic send_random_window();
    logic [PixBits-1:0] center;
    logic [127:0]       ring;
    int                 thr;
    int                 room;
    int                 len;
    int                 start;
    int                 extra;
    int                 v;
    bit                 up;
    thr = int'(checker_h.threshold);
    if ($urandom_range(99) < 35) begin
      center = 8'($urandom_range(255));
      ring   = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      up    = 1'($urandom_range(1));
      len   = $urandom_range(16, 6);
      start = $urandom_range(15);
      room  = (254 - thr > 0) ? 254 - thr : 0;
      center = up ? 8'($urandom_range(room)) : 8'(255 - $urandom_range(room));
      for (int i = 0; i < RingLen; i++) begin
        if (((i - start + RingLen) % RingLen) < len) begin
          extra = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4);
          // occasionally land exactly on the threshold to break the run
          if ($urandom_range(19) == 0) extra = -1;
          v = up ? int'(center) + thr + 1 + extra : int'(center) - thr - 1 - extra;
        end else if ($urandom_range(1)) begin
          v = $urandom_range(255);
        end else begin
          v = int'(center) + int'($urandom_range(2 * thr)) - thr;
        end
        ring[PixBits*i +: PixBits] = clamp_pixel(v);
      end
    end
    send_window(center, ring);
  endtask

  initial begin
    logic [PixBits-1:0] phase_thr[7];
    checker_h = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset threshold of 20
    send_window(8'd0, ring_by_mask(16'hFFFF, 8'hFF, 8'h00));
    send_window(8'd255, ring_by_mask(16'hFFFF, 8'h00, 8'hFF));
    send_window(8'd128, ring_by_mask(16'h0000, 8'h00, 8'd128));
    send_window(8'd100, ring_by_mask(16'hF01F, 8'd200, 8'd100));
    send_window(8'd100, ring_by_mask(16'hF00F, 8'd200, 8'd100));
    send_window(8'd100, ring_by_mask(16'h01FF, 8'd50, 8'd100));
    send_window(8'd100, ring_by_mask(16'h00FF, 8'd50, 8'd100));
    send_window(8'd100, ring_by_mask(16'hFFFF, 8'd120, 8'd0));
    send_window(8'd100, ring_by_mask(16'hFFFF, 8'd121, 8'd0));
    send_window(8'd100, ring_by_mask(16'hFFFF, 8'd80, 8'd0));
    send_window(8'd100, ring_by_mask(16'hFFFF, 8'd79, 8'd0));
    send_window(8'd128, ring_by_mask(16'h5555, 8'hFF, 8'h00));
    send_window(8'd128, ring_by_mask(16'h00FF, 8'hFF, 8'h00));
    send_window(8'hAA, ring_by_mask(16'hFFFF, 8'h55, 8'h00));
    send_window(8'h55, ring_by_mask(16'hFFFF, 8'hAA, 8'h00));
    send_window(8'd0, {64'h0F0E0D0C0B0A0908, 64'h0706050403020100});

    set_threshold(8'd255);
    send_window(8'd0, ring_by_mask(16'hFFFF, 8'hFF, 8'h00));
    send_window(8'd255, ring_by_mask(16'hFFFF, 8'h00, 8'hFF));

    set_threshold(8'd0);
    send_window(8'd100, ring_by_mask(16'hFFFF, 8'd101, 8'd0));
    send_window(8'd100, ring_by_mask(16'hFFFF, 8'd100, 8'd0));
    send_window(8'd100, ring_by_mask(16'hFFFF, 8'd99, 8'd0));

    phase_thr = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd20, 8'd0, 8'd0};
    phase_thr[5] = 8'($urandom_range(253, 2));
    phase_thr[6] = 8'($urandom_range(253, 2));
    for (int p = 0; p < 7; p++) begin
      set_threshold(phase_thr[p]);
      // one phase runs without any idling on either side
      idle_pct = (p == 3) ? 0 : 13;
      for (int n = 0; n < 205; n++) begin
        send_random_window();
      end
    end

    in_valid_i <= 1'b0;
    idle_pct = 13;
    while (checker_h.pending_scores.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (checker_h.errors == 0) begin
      $display("fast9_corner_score_top_tb OK");
    end else begin
      $display("fast9_corner_score_top_tb NOT OK");
    end
    $finish;
  end

endmodule
